// ----- design/itce_pkg.sv -----
`default_nettype none

package itce_pkg;

	localparam logic [15:0] CNT_MAX  = 16'hffff;
	localparam logic [3:0]  IHL_MIN  = 4'd5;
	localparam logic [15:0] MIN_SEEN = 16'd4;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_BAD   = 2'd2
	} status_t;

	// Snapshot of the running state taken on the last byte of a packet.
	typedef struct packed {
		logic [15:0] ip_sum;
		logic [15:0] tcp_sum;
		logic [7:0]  pending;
		logic [15:0] count;
		logic [15:0] total_len;
		logic [3:0]  ihl;
	} snap_t;

	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		logic [16:0] f;
		s = {1'b0, a} + {1'b0, b};
		f = {1'b0, s[15:0]} + {16'd0, s[16]};
		return f[15:0];
	endfunction

endpackage

`default_nettype wire

// ----- design/itce_accum.sv -----
`default_nettype none

module itce_accum (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [7:0]     packet_byte,
	input  wire logic           last_byte,
	input  wire logic           take,
	output logic                snap_valid_s1,
	output itce_pkg::snap_t     snap_s1
);

	logic [15:0] count_q;
	logic [3:0]  ihl_q;
	logic [15:0] total_len_q;
	logic [15:0] ip_sum_q;
	logic [15:0] tcp_sum_q;
	logic [7:0]  pending_q;

	logic        accept;
	logic [15:0] pos;
	logic [3:0]  ihl_n;
	logic [15:0] hdr;
	logic [15:0] total_len_n;
	logic        in_hdr;
	logic        in_seg;
	logic [15:0] off;
	logic        zero_byte;
	logic [7:0]  v;
	logic        odd;
	logic [15:0] word;
	logic [15:0] ip_sum_n;
	logic [15:0] tcp_add;
	logic        tcp_add_en;
	logic [15:0] tcp_sum_n;
	logic [7:0]  pending_n;
	logic [15:0] count_n;

	assign in_ready = !snap_valid_s1 || take;
	assign accept   = in_valid && in_ready;

	always_comb begin
		pos   = count_q;
		ihl_n = (pos == 16'd0) ? packet_byte[3:0] : ihl_q;
		hdr   = {10'd0, ihl_n, 2'b00};
		if (pos == 16'd2) begin
			total_len_n = {packet_byte, 8'h00};
		end else if (pos == 16'd3) begin
			total_len_n = {total_len_q[15:8], packet_byte};
		end else begin
			total_len_n = total_len_q;
		end
		in_hdr = pos < hdr;
		in_seg = !in_hdr && (pos < total_len_n) && (pos != itce_pkg::CNT_MAX);
		off    = pos - hdr;
		if (in_hdr) begin
			zero_byte = (pos == 16'd10) || (pos == 16'd11);
		end else begin
			zero_byte = (off == 16'd16) || (off == 16'd17);
		end
		v    = zero_byte ? 8'h00 : packet_byte;
		odd  = pos[0];
		word = {pending_q, v};

		ip_sum_n = (in_hdr && odd) ? itce_pkg::oc_add(ip_sum_q, word) : ip_sum_q;

		tcp_add    = word;
		tcp_add_en = 1'b0;
		if (in_hdr) begin
			if (pos == 16'd9) begin
				tcp_add    = {8'h00, packet_byte};
				tcp_add_en = 1'b1;
			end else if (odd && pos >= 16'd12 && pos <= 16'd19) begin
				tcp_add_en = 1'b1;
			end
		end else if (in_seg && odd) begin
			tcp_add_en = 1'b1;
		end
		tcp_sum_n = tcp_add_en ? itce_pkg::oc_add(tcp_sum_q, tcp_add) : tcp_sum_q;

		pending_n = ((in_hdr || in_seg) && !odd) ? v : pending_q;
		count_n   = (pos == itce_pkg::CNT_MAX) ? pos : pos + 16'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ihl_q       <= '0;
			total_len_q <= '0;
			ip_sum_q    <= '0;
			tcp_sum_q   <= '0;
			pending_q   <= '0;
		end else if (accept) begin
			if (last_byte) begin
				count_q     <= '0;
				ihl_q       <= '0;
				total_len_q <= '0;
				ip_sum_q    <= '0;
				tcp_sum_q   <= '0;
				pending_q   <= '0;
			end else begin
				count_q     <= count_n;
				ihl_q       <= ihl_n;
				total_len_q <= total_len_n;
				ip_sum_q    <= ip_sum_n;
				tcp_sum_q   <= tcp_sum_n;
				pending_q   <= pending_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s1 <= 1'b0;
		end else if (accept && last_byte) begin
			snap_valid_s1 <= 1'b1;
		end else if (take) begin
			snap_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_byte) begin
			snap_s1.ip_sum    <= ip_sum_n;
			snap_s1.tcp_sum   <= tcp_sum_n;
			snap_s1.pending   <= pending_n;
			snap_s1.count     <= count_n;
			snap_s1.total_len <= total_len_n;
			snap_s1.ihl       <= ihl_n;
		end
	end

endmodule

`default_nettype wire

// ----- design/itce_final.sv -----
`default_nettype none

module itce_final (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           snap_valid_s1,
	input  wire itce_pkg::snap_t snap_s1,
	output logic                take,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [15:0]         ip_checksum,
	output logic [15:0]         tcp_checksum,
	output logic [1:0]          status
);

	logic              out_valid_q;
	logic [15:0]       ip_ck_q;
	logic [15:0]       tcp_ck_q;
	itce_pkg::status_t status_q;

	logic [15:0]       hdr;
	logic [15:0]       seg_end;
	logic [15:0]       pad;
	logic [15:0]       tcp_len;
	logic [17:0]       sum3;
	logic [16:0]       fold1;
	logic [16:0]       fold2;
	itce_pkg::status_t status_n;

	assign take = snap_valid_s1 && (!out_valid_q || out_ready);

	always_comb begin
		hdr     = {10'd0, snap_s1.ihl, 2'b00};
		seg_end = (snap_s1.count < snap_s1.total_len) ? snap_s1.count : snap_s1.total_len;
		pad     = (seg_end > hdr && seg_end[0]) ? {snap_s1.pending, 8'h00} : 16'h0000;
		tcp_len = snap_s1.total_len - hdr;
		sum3    = {2'b00, snap_s1.tcp_sum} + {2'b00, pad} + {2'b00, tcp_len};
		fold1   = {1'b0, sum3[15:0]} + {15'd0, sum3[17:16]};
		fold2   = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};

		if (snap_s1.count < itce_pkg::MIN_SEEN) begin
			status_n = itce_pkg::ST_SHORT;
		end else if (snap_s1.ihl < itce_pkg::IHL_MIN || snap_s1.total_len < hdr) begin
			status_n = itce_pkg::ST_BAD;
		end else if (snap_s1.count < snap_s1.total_len) begin
			status_n = itce_pkg::ST_SHORT;
		end else begin
			status_n = itce_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ip_ck_q  <= ~snap_s1.ip_sum;
			tcp_ck_q <= ~fold2[15:0];
			status_q <= status_n;
		end
	end

	assign out_valid    = out_valid_q;
	assign ip_checksum  = ip_ck_q;
	assign tcp_checksum = tcp_ck_q;
	assign status       = status_q;

endmodule

`default_nettype wire

// ----- design/ipv4_tcp_checksum_engine_top.sv -----
// A last byte's result is registered in the snapshot stage, then in the output register.
// Throughput: one byte per cycle while in_ready is high.
// A finished packet waits in the snapshot stage while the output register is held.
// Reset is asynchronous and active low; it clears the running sums, counters and valid flags.
`default_nettype none

module ipv4_tcp_checksum_engine_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  packet_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      ip_checksum,
	output logic [15:0]      tcp_checksum,
	output logic [1:0]       status
);

	logic            take;
	logic            snap_valid_s1;
	itce_pkg::snap_t snap_s1;

	itce_accum u_accum (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.packet_byte   (packet_byte),
		.last_byte     (last_byte),
		.take          (take),
		.snap_valid_s1 (snap_valid_s1),
		.snap_s1       (snap_s1)
	);

	itce_final u_final (
		.clk           (clk),
		.arst_n        (arst_n),
		.snap_valid_s1 (snap_valid_s1),
		.snap_s1       (snap_s1),
		.take          (take),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.ip_checksum   (ip_checksum),
		.tcp_checksum  (tcp_checksum),
		.status        (status)
	);

endmodule

`default_nettype wire

// ----- design/itce_checker.sv -----
`default_nettype none

module itce_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [7:0]  packet_byte,
	input wire logic        last_byte,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] ip_checksum,
	input wire logic [15:0] tcp_checksum,
	input wire logic [1:0]  status
);

	logic last_acc;
	assign last_acc = in_valid && in_ready && last_byte;

	// A held result keeps its value until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ip_checksum)
			&& $stable(tcp_checksum) && $stable(status))
		else $error("held result changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("undefined status code");

	// A new result only follows an accepted last byte that has passed through the snapshot register.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) && $past(arst_n, 2) |-> $past(last_acc, 2))
		else $error("result without a preceding last byte");

	// With a finished packet queued and the output held, no further request is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) && $past(last_acc) && out_valid && !out_ready |-> !in_ready)
		else $error("input accepted while both result stages are full");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(packet_byte) && $stable(last_byte))
		else $error("stalled request changed");

endmodule

bind ipv4_tcp_checksum_engine_top itce_checker u_itce_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.packet_byte  (packet_byte),
	.last_byte    (last_byte),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.ip_checksum  (ip_checksum),
	.tcp_checksum (tcp_checksum),
	.status       (status)
);

`default_nettype wire
